// ===== rtl/core/fba_pkg.sv =====
// Shared types and constants of the frame bitmap allocator.
// No dependencies; every other file of the block but fba_ram imports this package.
package fba_pkg;

    localparam int MAX_FRAMES = 4096;
    localparam int WORD_BITS  = 32;
    localparam int NUM_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int FRAME_W    = 12;
    localparam int CFG_W      = 13;
    localparam int LIMIT_W    = CFG_W - BIT_W;
    localparam int STATUS_W   = 2;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST = CFG_W'(4096);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

    // Response kinds requested by the controller
    localparam logic [1:0] RSP_WROTE = 2'd0;
    localparam logic [1:0] RSP_NOCHG = 2'd1;
    localparam logic [1:0] RSP_FULL  = 2'd2;

    typedef struct packed {
        logic               operation;
        logic [FRAME_W-1:0] entry_frame;
        logic               kernel_page;
        logic               writable;
    } t_fba_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic                present;
        logic                rw;
        logic                user;
    } t_fba_rsp;

    typedef struct packed {
        logic       accept;
        logic       scan;
        logic       issue_free;
        logic       capture;
        logic       write;
        logic       rsp_en;
        logic [1:0] rsp_kind;
    } t_fba_cmd;

    typedef struct packed {
        logic req_nochg;
        logic req_free;
        logic pend;
        logic full;
        logic scan_end;
    } t_fba_sts;

endpackage

// ===== rtl/core/fba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fba_ctrl.sv =====
// Controller of the frame bitmap allocator: sequences scan, free and write-back.
// Depends on fba_pkg.
module fba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    input  fba_pkg::t_fba_sts i_sts,
    output fba_pkg::t_fba_cmd o_cmd
);
    import fba_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FRD   = 3'd2;
    localparam logic [2:0] S_FCAP  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;
    localparam logic [2:0] S_NOCH  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_fba_cmd   cmd;

    always_comb begin
        n_state      = r_state;
        cmd          = '0;
        cmd.rsp_kind = RSP_WROTE;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    cmd.accept = 1'b1;
                    if (i_sts.req_nochg) begin
                        n_state = S_NOCH;
                    end else if (i_sts.req_free) begin
                        n_state = S_FRD;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (i_sts.pend && !i_sts.full) begin
                    cmd.capture = 1'b1;
                    n_state     = S_WRITE;
                end else if (i_sts.scan_end) begin
                    // nothing left in flight and no word with a clear bit
                    cmd.rsp_en   = 1'b1;
                    cmd.rsp_kind = RSP_FULL;
                    n_state      = S_IDLE;
                end
            end
            S_FRD: begin
                cmd.issue_free = 1'b1;
                n_state        = S_FCAP;
            end
            S_FCAP: begin
                cmd.capture = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                cmd.write    = 1'b1;
                cmd.rsp_en   = 1'b1;
                cmd.rsp_kind = RSP_WROTE;
                n_state      = S_IDLE;
            end
            S_NOCH: begin
                cmd.rsp_en   = 1'b1;
                cmd.rsp_kind = RSP_NOCHG;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

`ifndef ASSERT_OFF
    a_rsp_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.rsp_en |=> (r_state == S_IDLE))
        else $error("response did not return the controller to idle");
    a_found_goes_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && i_sts.pend && !i_sts.full |=> (r_state == S_WRITE))
        else $error("free bit found but no write-back followed");
    a_write_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.write |=> !cmd.write && !o_busy)
        else $error("write-back not a single cycle at the end of an item");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.accept |-> $past(cmd.rsp_en) || (r_state == S_IDLE))
        else $error("transfer accepted outside idle");
`endif

endmodule

// ===== rtl/core/fba_datapath.sv =====
// Datapath of the frame bitmap allocator: bitmap RAM, word valid bits,
// scan counter, lowest-clear-bit search and result register.
// Depends on fba_pkg and fba_ram.
module fba_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fba_pkg::t_fba_req           i_req,
    input  logic                        i_cfg_we,
    input  logic [fba_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  fba_pkg::t_fba_cmd           i_cmd,
    output fba_pkg::t_fba_sts           o_sts,
    output logic                        o_done,
    output fba_pkg::t_fba_rsp           o_rsp
);
    import fba_pkg::*;

    logic [CFG_W-1:0]     r_frame_count;
    t_fba_req             r_req;
    logic [LIMIT_W-1:0]   r_addr;
    logic                 r_pend;
    logic [WADDR_W-1:0]   r_dat_addr;
    logic [WORD_BITS-1:0] r_word;
    logic [WADDR_W-1:0]   r_word_addr;
    logic [NUM_WORDS-1:0] r_valid;
    logic                 r_done;
    t_fba_rsp             r_rsp;

    logic [LIMIT_W-1:0]   cfg_words;
    logic [LIMIT_W-1:0]   limit;
    logic                 scan_end;
    logic                 scan_rd;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic [WORD_BITS-1:0] rd_data;
    logic [WORD_BITS-1:0] word_eff;
    logic [WORD_BITS-1:0] low_zero;
    logic [BIT_W-1:0]     low_idx;
    logic [WORD_BITS-1:0] free_mask;
    logic [WORD_BITS-1:0] wr_data;
    t_fba_rsp             n_rsp;

    assign cfg_words = r_frame_count[CFG_W-1:BIT_W];
    assign limit     = (cfg_words > LIMIT_W'(NUM_WORDS)) ? LIMIT_W'(NUM_WORDS) : cfg_words;
    assign scan_end  = (r_addr >= limit);
    assign scan_rd   = i_cmd.scan && !scan_end;
    assign rd_en     = scan_rd || i_cmd.issue_free;
    assign rd_addr   = i_cmd.scan ? r_addr[WADDR_W-1:0]
                                  : r_req.entry_frame[BIT_W +: WADDR_W];

    fba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_word_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // words never written since reset read as all free
    assign word_eff = r_valid[r_dat_addr] ? rd_data : '0;

    // isolate lowest clear bit, then encode it
    assign low_zero = ~r_word & (r_word + WORD_BITS'(1));
    always_comb begin
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            if (low_zero[i]) begin
                low_idx = low_idx | BIT_W'(i);
            end
        end
    end

    assign free_mask = WORD_BITS'(1) << r_req.entry_frame[BIT_W-1:0];
    assign wr_data   = (r_req.operation == OP_FREE) ? (r_word & ~free_mask)
                                                    : (r_word | low_zero);

    always_comb begin
        n_rsp = '0;
        case (i_cmd.rsp_kind)
            RSP_WROTE: begin
                n_rsp.status = ST_DONE;
                if (r_req.operation == OP_ALLOC) begin
                    n_rsp.frame   = FRAME_W'({r_word_addr, low_idx});
                    n_rsp.present = 1'b1;
                    n_rsp.rw      = r_req.writable;
                    n_rsp.user    = ~r_req.kernel_page;
                end
            end
            RSP_NOCHG: begin
                n_rsp.status = ST_NOCHANGE;
                n_rsp.frame  = r_req.entry_frame;
            end
            RSP_FULL: begin
                n_rsp.status = ST_FULL;
                n_rsp.frame  = r_req.entry_frame;
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= FRAME_COUNT_RST;
            r_valid       <= '0;
            r_pend        <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frame_count <= i_cfg_wdata;
            end
            if (i_cmd.write) begin
                r_valid[r_word_addr] <= 1'b1;
            end
            r_pend <= scan_rd;
            r_done <= i_cmd.rsp_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_req;
            r_addr <= '0;
        end else if (scan_rd) begin
            r_addr <= r_addr + LIMIT_W'(1);
        end
        if (rd_en) begin
            r_dat_addr <= rd_addr;
        end
        if (i_cmd.capture) begin
            r_word      <= word_eff;
            r_word_addr <= r_dat_addr;
        end
        if (i_cmd.rsp_en) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.req_nochg = (i_req.operation == OP_ALLOC) ? (i_req.entry_frame != '0)
                                                           : (i_req.entry_frame == '0);
    assign o_sts.req_free  = (i_req.operation == OP_FREE);
    assign o_sts.pend      = r_pend;
    assign o_sts.full      = (word_eff == '1);
    assign o_sts.scan_end  = scan_end;
    assign o_done          = r_done;
    assign o_rsp           = r_rsp;

`ifndef ASSERT_OFF
    a_alloc_word_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write && (r_req.operation == OP_ALLOC) |-> (r_word != '1))
        else $error("allocation write-back into a full bitmap word");
    a_alloc_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write && (r_req.operation == OP_ALLOC) |-> $onehot(low_zero))
        else $error("lowest clear bit search not one-hot");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_rd |-> (r_addr < LIMIT_W'(NUM_WORDS)))
        else $error("scan read beyond the bitmap");
`endif

endmodule

// ===== rtl/core/frame_bitmap_allocator.sv =====
// Top level of the first-fit page frame allocator.
// Depends on fba_pkg, fba_ctrl, fba_datapath (which holds fba_ram).
//
// One request is taken when start is high and busy is low; its single result
// shows on o_rsp for one cycle with o_done and must be taken then, as the
// block cannot hold it. A no-change request keeps busy high in S_NOCH only,
// a free in S_FRD, S_FCAP and S_WRITE. An allocation reads one bitmap word
// per cycle from the bitmap RAM, lowest first, until a word has a clear bit
// (then written back in S_WRITE) or L = min(frame_count/32, 128) words are
// scanned and it reports full. The result shows in the first cycle with busy
// low. The bitmap reads as all free after reset with no clearing pass. The
// user must write frame_count through i_cfg_we/i_cfg_wdata only while no
// request is in flight; the block itself does not enforce it.
module frame_bitmap_allocator (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  fba_pkg::t_fba_req         i_req,
    output logic                      o_done,
    output fba_pkg::t_fba_rsp         o_rsp,
    input  logic                      i_cfg_we,
    input  logic [fba_pkg::CFG_W-1:0] i_cfg_wdata
);
    import fba_pkg::*;

    t_fba_cmd cmd;
    t_fba_sts sts;

    fba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fba_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule
